// File: rtl/core/cbe_pkg.sv
// ============================================================================
// cbe_pkg: shared types and constants for the cubic Bezier point evaluator
// Coordinate format (signed Q16.8), control point bundles, pipeline depths.
// ============================================================================
`default_nettype none

package cbe_pkg;

    // Coordinate format: signed Q16.8
    localparam int COORD_W   = 24;
    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;

    // Pipeline depths: weight generator stages, then total stages to the result
    localparam int WEIGHT_STAGES = 4;
    localparam int NUM_STAGES    = 8;

    // Number of control points of a cubic curve
    localparam int NUM_PTS = 4;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One coordinate axis of P0..P3, index 0 is the start point
    typedef coord_t [NUM_PTS-1:0] coord_set_t;

    typedef struct packed {
        coord_set_t px;
        coord_set_t py;
    } ctrl_pts_t;

endpackage

`default_nettype wire

// File: rtl/core/cbe_weight_gen.sv
// ============================================================================
// cbe_weight_gen: Bernstein weight pipeline
// Clamps t, forms r = 1 - t and the exact weights r^3, 3tr^2, 3t^2r, t^3
// over four register stages. Weights carry 3*T_FRAC_BITS fraction bits.
// ============================================================================
`default_nettype none

module cbe_weight_gen #(
    parameter  int T_FRAC_BITS = 16,
    localparam int WW          = 3*T_FRAC_BITS + 1
) (
    input  logic                   clk,
    input  logic [T_FRAC_BITS:0]   curve_t,
    output logic [3:0][WW-1:0]     weight
);

    import cbe_pkg::*;

    localparam int F   = T_FRAC_BITS;
    localparam int TW  = F + 1;        // t and r width
    localparam int SQW = 2*F + 1;      // t*t, t*r, r*r fit here (max 2^2F)
    localparam int BW  = 3*F + 3;      // headroom for the x3 scaling

    localparam logic [TW-1:0] T_ONE = {1'b1, {F{1'b0}}};

    // stage 1: clamp and complement
    logic [TW-1:0] t_next;
    logic [TW-1:0] t1_reg, r1_reg;

    assign t_next = (curve_t > T_ONE) ? T_ONE : curve_t;

    always_ff @(posedge clk)
    begin
        t1_reg <= t_next;
        r1_reg <= T_ONE - t_next;
    end

    // stage 2: squares and cross product
    logic [2*TW-1:0] tt_full, tr_full, rr_full;
    logic [SQW-1:0]  tt2_reg, tr2_reg, rr2_reg;
    logic [TW-1:0]   t2_reg, r2_reg;

    assign tt_full = t1_reg * t1_reg;
    assign tr_full = t1_reg * r1_reg;
    assign rr_full = r1_reg * r1_reg;

    always_ff @(posedge clk)
    begin
        tt2_reg <= tt_full[SQW-1:0];
        tr2_reg <= tr_full[SQW-1:0];
        rr2_reg <= rr_full[SQW-1:0];
        t2_reg  <= t1_reg;
        r2_reg  <= r1_reg;
    end

    // stage 3: third factor, square split in halves to keep multipliers narrow
    logic [3:0][SQW-1:0]    sq;
    logic [3:0][TW-1:0]     mul;
    logic [3:0][2*TW-1:0]   pl_next;
    logic [3:0][F+TW-1:0]   ph_next;
    logic [3:0][2*TW-1:0]   pl3_reg;
    logic [3:0][F+TW-1:0]   ph3_reg;

    always_comb
    begin
        sq[0] = rr2_reg;  mul[0] = r2_reg;   // r^3
        sq[1] = tr2_reg;  mul[1] = r2_reg;   // t r^2
        sq[2] = tt2_reg;  mul[2] = r2_reg;   // t^2 r
        sq[3] = tt2_reg;  mul[3] = t2_reg;   // t^3
        for (int i = 0; i < 4; i++)
        begin
            pl_next[i] = (2*TW)'(sq[i][TW-1:0]) * (2*TW)'(mul[i]);
            ph_next[i] = (F+TW)'(sq[i][SQW-1:TW]) * (F+TW)'(mul[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        pl3_reg <= pl_next;
        ph3_reg <= ph_next;
    end

    // stage 4: recombine halves, apply binomial factor 3 on the middle terms
    logic [3:0][BW-1:0] base;
    logic [3:0][WW-1:0] weight_next;
    logic [3:0][WW-1:0] weight_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            base[i] = (BW'(ph3_reg[i]) << TW) + BW'(pl3_reg[i]);
            if (i == 1 || i == 2)
            begin
                base[i] = base[i] + (base[i] << 1);
            end
            weight_next[i] = base[i][WW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
    end

    assign weight = weight_reg;

endmodule

`default_nettype wire

// File: rtl/core/cbe_coord_acc.sv
// ============================================================================
// cbe_coord_acc: weighted sum for one coordinate axis
// Exact sum of P_i * w_i over four register stages, then round to nearest
// (ties up) and saturate to signed Q16.8.
// ============================================================================
`default_nettype none

module cbe_coord_acc #(
    parameter  int T_FRAC_BITS = 16,
    localparam int WW          = 3*T_FRAC_BITS + 1
) (
    input  logic                clk,
    input  cbe_pkg::coord_set_t pts,
    input  logic [3:0][WW-1:0]  weight,
    output cbe_pkg::coord_t     point
);

    import cbe_pkg::*;

    localparam int WL    = (WW + 1) / 2;        // low weight half
    localparam int WH    = WW - WL;             // high weight half
    localparam int PLW   = COORD_W + WL + 1;
    localparam int PHW   = COORD_W + WH + 1;
    localparam int ACC_W = COORD_W + WW + 3;
    localparam int SHIFT = 3*T_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] RND =
        {{(ACC_W-SHIFT){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(COORD_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(COORD_MIN);

    // stage 5: partial products against weight halves
    logic signed [PLW-1:0] plo_next [4];
    logic signed [PHW-1:0] phi_next [4];
    logic signed [PLW-1:0] plo_reg  [4];
    logic signed [PHW-1:0] phi_reg  [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            plo_next[i] = $signed(pts[i]) * $signed({1'b0, weight[i][WL-1:0]});
            phi_next[i] = $signed(pts[i]) * $signed({1'b0, weight[i][WW-1:WL]});
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg <= plo_next;
        phi_reg <= phi_next;
    end

    // stage 6: full terms
    logic signed [ACC_W-1:0] term_reg [4];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            term_reg[i] <= (ACC_W'(phi_reg[i]) <<< WL) + ACC_W'(plo_reg[i]);
        end
    end

    // stage 7: pairwise sums
    logic signed [ACC_W-1:0] pair_reg [2];

    always_ff @(posedge clk)
    begin
        pair_reg[0] <= term_reg[0] + term_reg[1];
        pair_reg[1] <= term_reg[2] + term_reg[3];
    end

    // stage 8: final sum, round, saturate
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] scaled;
    coord_t                  point_next;
    coord_t                  point_reg;

    always_comb
    begin
        sum    = pair_reg[0] + pair_reg[1] + RND;
        scaled = sum >>> SHIFT;
        if (scaled > SAT_HI)
        begin
            point_next = coord_t'(COORD_MAX);
        end
        else if (scaled < SAT_LO)
        begin
            point_next = coord_t'(COORD_MIN);
        end
        else
        begin
            point_next = scaled[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
    end

    assign point = point_reg;

endmodule

`default_nettype wire

// File: rtl/core/cubic_bezier_point_eval_core.sv
// ============================================================================
// cubic_bezier_point_eval_core: 2D cubic Bezier point evaluator
// Returns B(t) = P0 r^3 + 3 P1 t r^2 + 3 P2 t^2 r + P3 t^3, r = 1 - t.
// ============================================================================
//
// Usage
//   Command channel: drive the four points and curve_t and raise start. A
//   transfer takes place at each rising edge with start high and busy low.
//   busy is held low: the pipeline takes a new point every clock cycle.
//   Result channel: strobe is high for exactly one cycle with point_x and
//   point_y valid; that cycle's ending edge is the transfer. There is no
//   back-pressure, results leave in command order.
//   Pipeline: 8 register stages, 4 in the weight generator and 4 in each
//   coordinate accumulator; strobe rises together with the results of the last.
//   Throughput: one point per cycle, set by the fully pipelined multipliers.
//   curve_t above 1.0 (2^T_FRAC_BITS) is clamped to 1.0. Results are rounded
//   to nearest, ties up, and saturated to the Q16.8 range.
//   Reset: rst_n clears the valid pipeline; items in flight are dropped and
//   no strobe is issued for them. Datapath registers are not reset.
// ============================================================================
`default_nettype none

module cubic_bezier_point_eval_core #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cbe_pkg::coord_t      start_x,
    input  cbe_pkg::coord_t      start_y,
    input  cbe_pkg::coord_t      ctrl1_x,
    input  cbe_pkg::coord_t      ctrl1_y,
    input  cbe_pkg::coord_t      ctrl2_x,
    input  cbe_pkg::coord_t      ctrl2_y,
    input  cbe_pkg::coord_t      end_x,
    input  cbe_pkg::coord_t      end_y,
    input  logic [T_FRAC_BITS:0] curve_t,
    output logic                 strobe,
    output cbe_pkg::coord_t      point_x,
    output cbe_pkg::coord_t      point_y
);

    import cbe_pkg::*;

    localparam int WW = 3*T_FRAC_BITS + 1;   // weight width, 3F fraction bits

    // Command transfer; the pipeline never stalls
    logic accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Valid bits travel alongside the datapath stages
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;

    assign vld_next = {vld_reg[NUM_STAGES-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign strobe = vld_reg[NUM_STAGES-1];

    // Control points ride along while the weights are formed
    ctrl_pts_t pts_next;
    ctrl_pts_t pts_reg [WEIGHT_STAGES];

    always_comb
    begin
        pts_next.px[0] = start_x;
        pts_next.px[1] = ctrl1_x;
        pts_next.px[2] = ctrl2_x;
        pts_next.px[3] = end_x;
        pts_next.py[0] = start_y;
        pts_next.py[1] = ctrl1_y;
        pts_next.py[2] = ctrl2_y;
        pts_next.py[3] = end_y;
    end

    always_ff @(posedge clk)
    begin
        pts_reg[0] <= pts_next;
        for (int i = 1; i < WEIGHT_STAGES; i++)
        begin
            pts_reg[i] <= pts_reg[i-1];
        end
    end

    // Bernstein weights, aligned with pts_reg[WEIGHT_STAGES-1]
    logic [3:0][WW-1:0] weight;

    cbe_weight_gen #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_weight (
        .clk     (clk),
        .curve_t (curve_t),
        .weight  (weight)
    );

    // One accumulator per axis
    cbe_coord_acc #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_acc_x (
        .clk    (clk),
        .pts    (pts_reg[WEIGHT_STAGES-1].px),
        .weight (weight),
        .point  (point_x)
    );

    cbe_coord_acc #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_acc_y (
        .clk    (clk),
        .pts    (pts_reg[WEIGHT_STAGES-1].py),
        .weight (weight),
        .point  (point_y)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Partition of unity: weights of a valid item sum to exactly 1.0
    localparam logic [WW+1:0] W_ONE = {{2{1'b0}}, 1'b1, {(WW-1){1'b0}}};

    logic [WW+1:0] w_sum;

    assign w_sum = (WW+2)'(weight[0]) + (WW+2)'(weight[1])
                 + (WW+2)'(weight[2]) + (WW+2)'(weight[3]);

    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[WEIGHT_STAGES-1] |-> (w_sum == W_ONE))
        else $error("Bernstein weights do not sum to one");

    // A result strobe always traces back to a command transfer
    a_strobe_origin: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(vld_reg[0], NUM_STAGES-1))
        else $error("result strobe without matching command transfer");

endmodule

`default_nettype wire

// File: test/tb.sv
// ============================================================================
// tb: self-checking testbench for cubic_bezier_point_eval_core
// Streams curve points through the command channel with random gaps, predicts
// each point from the Bernstein-weighted sum (exact, then rounded and
// saturated) and checks every strobed result in order against the prediction.
// ============================================================================

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cbe_pkg::*;

    // t format: unsigned Q1.TF, T_ONE is 1.0
    localparam int          TF       = 16;
    localparam logic [TF:0] T_ONE    = (TF+1)'(1) << TF;
    localparam logic [TF:0] T_HALF   = (TF+1)'(1) << (TF - 1);
    localparam int          N_RANDOM = 650;

    // Coordinate extremes in port format
    localparam coord_t      C_MAX    = coord_t'(COORD_MAX);
    localparam coord_t      C_MIN    = coord_t'(COORD_MIN);

    // One evaluation request, drain_first holds it back until the pipe is empty
    typedef struct {
        coord_t      start_x;
        coord_t      start_y;
        coord_t      ctrl1_x;
        coord_t      ctrl1_y;
        coord_t      ctrl2_x;
        coord_t      ctrl2_y;
        coord_t      end_x;
        coord_t      end_y;
        logic [TF:0] curve_t;
        bit          drain_first;
    } curve_cmd_t;

    typedef struct {
        coord_t point_x;
        coord_t point_y;
    } curve_point_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    coord_t      start_x = '0;
    coord_t      start_y = '0;
    coord_t      ctrl1_x = '0;
    coord_t      ctrl1_y = '0;
    coord_t      ctrl2_x = '0;
    coord_t      ctrl2_y = '0;
    coord_t      end_x = '0;
    coord_t      end_y = '0;
    logic [TF:0] curve_t = '0;
    logic        strobe;
    coord_t      point_x;
    coord_t      point_y;

    curve_cmd_t   pending_curves[$];
    curve_point_t expected_points[$];

    bit cmd_taken = 1'b0;   // the command on the ports transferred at the last edge
    int sent_cnt = 0;       // commands put on the ports so far
    int accepted_cnt = 0;
    int clamped_cnt = 0;    // accepted commands with t above 1.0
    int points_checked = 0;
    int fail_cnt = 0;

    cubic_bezier_point_eval_core #(
        .T_FRAC_BITS(TF)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .start_x(start_x),
        .start_y(start_y),
        .ctrl1_x(ctrl1_x),
        .ctrl1_y(ctrl1_y),
        .ctrl2_x(ctrl2_x),
        .ctrl2_y(ctrl2_y),
        .end_x  (end_x),
        .end_y  (end_y),
        .curve_t(curve_t),
        .strobe (strobe),
        .point_x(point_x),
        .point_y(point_y)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: one axis of B(t). The sum is kept exact in a wide signed
    // accumulator (3*TF + 8 fraction bits), then rounded to nearest with ties
    // toward +inf and saturated to the Q16.8 range.
    // ------------------------------------------------------------------------
    function automatic coord_t bezier_axis(input coord_t p0, input coord_t p1,
                                           input coord_t p2, input coord_t p3,
                                           input logic [TF:0] t_raw);
        logic [TF:0]         t_c;
        logic signed [111:0] t_w;
        logic signed [111:0] r_w;
        logic signed [111:0] acc;
        t_c = (t_raw > T_ONE) ? T_ONE : t_raw;     // t above one clamps to one
        t_w = 112'(t_c);
        r_w = 112'(T_ONE - t_c);
        acc = p0 * r_w * r_w * r_w
            + 3 * p1 * t_w * r_w * r_w
            + 3 * p2 * t_w * t_w * r_w
            + p3 * t_w * t_w * t_w;
        acc = acc + (112'sd1 <<< (3 * TF - 1));
        acc = acc >>> (3 * TF);
        if (acc > COORD_MAX)
            return C_MAX;
        if (acc < COORD_MIN)
            return C_MIN;
        return acc[COORD_W-1:0];
    endfunction

    function automatic coord_t rand_coord();
        // Mostly full range, sometimes small values near zero
        if ($urandom_range(3) == 0)
            return coord_t'($signed($urandom_range(2047)) - 1024);
        return coord_t'($urandom);
    endfunction

    function automatic logic [TF:0] rand_t();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return (TF+1)'($urandom_range(int'(T_ONE)));
        if (sel < 85)
            return (TF+1)'($urandom);               // full field, often above one
        case ($urandom_range(3))
            0: return '0;
            1: return T_ONE;
            2: return (TF+1)'(1);
            default: return T_ONE - 1'b1;
        endcase
    endfunction

    task automatic add_curve(input coord_t sx, input coord_t sy, input coord_t c1x,
                             input coord_t c1y, input coord_t c2x, input coord_t c2y,
                             input coord_t ex, input coord_t ey, input logic [TF:0] t,
                             input bit drain);
        curve_cmd_t c;
        c.start_x = sx;
        c.start_y = sy;
        c.ctrl1_x = c1x;
        c.ctrl1_y = c1y;
        c.ctrl2_x = c2x;
        c.ctrl2_y = c2y;
        c.end_x = ex;
        c.end_y = ey;
        c.curve_t = t;
        c.drain_first = drain;
        pending_curves.push_back(c);
    endtask

    // ------------------------------------------------------------------------
    // Driver: updates the command ports at the falling edge. A new command is
    // put up only when the port is free (nothing shown, or the last one
    // transferred). Random gaps, except for a gap-free stretch in the middle.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!start || cmd_taken))
        begin
            if (pending_curves.size() == 0)
                start <= 1'b0;
            else if (!(sent_cnt >= 250 && sent_cnt < 450) && $urandom_range(99) < 8)
                start <= 1'b0;
            else if (pending_curves[0].drain_first && expected_points.size() != 0)
                start <= 1'b0;      // hold until every point in flight is back
            else
            begin
                start_x <= pending_curves[0].start_x;
                start_y <= pending_curves[0].start_y;
                ctrl1_x <= pending_curves[0].ctrl1_x;
                ctrl1_y <= pending_curves[0].ctrl1_y;
                ctrl2_x <= pending_curves[0].ctrl2_x;
                ctrl2_y <= pending_curves[0].ctrl2_y;
                end_x <= pending_curves[0].end_x;
                end_y <= pending_curves[0].end_y;
                curve_t <= pending_curves[0].curve_t;
                start <= 1'b1;
                void'(pending_curves.pop_front());
                sent_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at the rising edge, check a strobed point against the oldest
    // prediction, then record a command transfer and predict its point.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        curve_point_t exp_pt;
        curve_point_t new_pt;
        if (rst_n && strobe)
        begin
            if (expected_points.size() == 0)
            begin
                $error("point strobed with none outstanding: x=%0d y=%0d",
                       point_x, point_y);
                fail_cnt++;
            end
            else
            begin
                exp_pt = expected_points.pop_front();
                points_checked++;
                if (point_x !== exp_pt.point_x)
                begin
                    $error("point_x mismatch: expected %0d, actual %0d",
                           exp_pt.point_x, point_x);
                    fail_cnt++;
                end
                if (point_y !== exp_pt.point_y)
                begin
                    $error("point_y mismatch: expected %0d, actual %0d",
                           exp_pt.point_y, point_y);
                    fail_cnt++;
                end
            end
        end
        cmd_taken <= rst_n && start && (busy === 1'b0);
        if (rst_n && start && busy === 1'b0)
        begin
            new_pt.point_x = bezier_axis(start_x, ctrl1_x, ctrl2_x, end_x, curve_t);
            new_pt.point_y = bezier_axis(start_y, ctrl1_y, ctrl2_y, end_y, curve_t);
            expected_points.push_back(new_pt);
            accepted_cnt++;
            if (curve_t > T_ONE)
                clamped_cnt++;
        end
    end

    initial
    begin
        int i;

        // Directed: endpoints of t, clamping, extreme coordinates, rounding ties
        add_curve('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        add_curve(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX,
                  C_MIN, C_MAX, '0, 1'b0);
        add_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN,
                  C_MAX, C_MIN, T_ONE, 1'b0);
        add_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), C_MAX, C_MIN, T_ONE + 1'b1, 1'b0);
        add_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), C_MIN, C_MAX, '1, 1'b0);
        add_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                  C_MAX, C_MAX, T_HALF, 1'b0);
        add_curve(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                  C_MIN, C_MIN, T_HALF, 1'b0);
        add_curve(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
                  C_MAX, C_MIN, (TF+1)'(12345), 1'b0);
        add_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN,
                  C_MIN, C_MAX, T_HALF, 1'b0);
        add_curve(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX,
                  C_MAX, C_MIN, (TF+1)'(1), 1'b0);
        add_curve(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX,
                  C_MIN, C_MAX, T_ONE - 1'b1, 1'b0);
        // Exact half-LSB sums: +0.5 rounds up, -0.5 rounds to zero
        add_curve(24'sd4, '0, '0, '0, '0, '0, '0, 24'sd4, T_HALF, 1'b1);
        add_curve(-24'sd4, '0, '0, '0, '0, '0, '0, -24'sd4, T_HALF, 1'b0);
        add_curve('0, 24'sd12, 24'sd4, '0, '0, -24'sd4, '0, '0, T_HALF, 1'b0);
        add_curve(24'sd1, -24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1,
                  T_HALF, 1'b0);
        add_curve(-24'sd1, 24'sd1, '0, '0, '0, '0, 24'sd1, -24'sd1, (TF+1)'(3), 1'b0);
        add_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), T_ONE + T_HALF, 1'b0);

        // Random part, with one drain pause partway through
        for (i = 0; i < N_RANDOM; i++)
            add_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_t(), i == 500);

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        while (pending_curves.size() != 0 || start || expected_points.size() != 0)
            @(negedge clk);
        repeat (NUM_STAGES + 4) @(negedge clk);

        $display("Evaluated %0d curve points (%0d with t clamped to one), %0d checked.",
                 accepted_cnt, clamped_cnt, points_checked);
        $display("Stimulus: t endpoints, extreme coordinates, rounding ties, random.");
        if (fail_cnt == 0 && expected_points.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial
    begin
        #200000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
